// ===== hdl/lmle_pkg.sv =====
package lmle_pkg;

  localparam int unsigned LogTableBitsDef = 8;
  localparam int unsigned CountWidthDef   = 16;
  localparam int unsigned CfgW            = 16;
  localparam int unsigned RateW           = 31;
  localparam int unsigned ExpoW           = 32;
  localparam int unsigned SumW            = 52;
  localparam int unsigned DivW            = 51;
  localparam int unsigned FracW           = 24;

  localparam logic [CfgW-1:0] TransientReset = 16'd1000;
  localparam logic [CfgW-1:0] IterationReset = 16'd1000;

  localparam logic REG_TRANSIENT = 1'b0;
  localparam logic REG_ITERATION = 1'b1;

  localparam logic [31:0] HalfQ31 = 32'h4000_0000;
  localparam logic [32:0] OneQ31  = 33'h0_8000_0000;
  localparam logic [31:0] Ln2Q32  = 32'hB172_17F8;
  localparam logic signed [SumW-1:0] LogFloor = -52'sd11576279040;

  function automatic logic [FracW-1:0] frac_entry(int unsigned i, int unsigned bits);
    logic [63:0] y;
    logic [FracW-1:0] acc;
    y = 64'h4000_0000 + (64'(i) << (30 - bits));
    acc = '0;
    for (int k = 0; k < FracW; k++) begin
      y = (y * y) >> 30;
      acc = {acc[FracW-2:0], 1'b0};
      if (y >= 64'h8000_0000) begin
        y = y >> 1;
        acc[0] = 1'b1;
      end
    end
    return acc;
  endfunction

endpackage

// ===== hdl/lmle_div.sv =====
module lmle_div #(
  parameter int unsigned DW = 51,
  parameter int unsigned VW = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quotient_o
);

  localparam int unsigned CntW = $clog2(DW + 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [VW:0]     rem_q, rem_d;
  logic [DW-1:0]   dq_q, dq_d;
  logic [VW-1:0]   dv_q, dv_d;
  logic [VW:0]     rem_sh;
  logic            ge;

  always_comb begin
    rem_sh = {rem_q[VW-1:0], dq_q[DW-1]};
    ge     = rem_sh >= {1'b0, dv_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dq_d   = dq_q;
    dv_d   = dv_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(DW);
      rem_d  = '0;
      dq_d   = dividend_i;
      dv_d   = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? (rem_sh - {1'b0, dv_q}) : rem_sh;
      dq_d  = {dq_q[DW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dq_q  <= dq_d;
    dv_q  <= dv_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dq_q;

endmodule

// ===== hdl/logistic_map_lyapunov_estimator_unit.sv =====
// Channel  | Ports                                              | Direction
// request  | start, growth_rate_i (busy is an output)           | in
// result   | done_o, exponent_o, zero_derivative_seen_o,        | out
//          | saturated_o                                        |
// config   | cfg_we_i, cfg_idx_i, cfg_data_i                    | in
// A request keeps busy high through T transient and M measured iterations, paced by the
// one shared 33x32 multiplier, the six-step normalizer and the 51-step divider; a zero
// derivative shortens its iteration. With M at zero only the transient iterations run.
// Reset clears the sequencer and loads both counts with 1000.
// A result is shown for one cycle on done_o as busy falls and cannot be held off.
module logistic_map_lyapunov_estimator_unit
  import lmle_pkg::*;
#(
  parameter int unsigned LOG_TABLE_BITS = LogTableBitsDef,
  parameter int unsigned COUNT_WIDTH    = CountWidthDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [RateW-1:0]        growth_rate_i,
  input  logic                    cfg_we_i,
  input  logic                    cfg_idx_i,
  input  logic [CfgW-1:0]         cfg_data_i,
  output logic                    done_o,
  output logic signed [ExpoW-1:0] exponent_o,
  output logic                    zero_derivative_seen_o,
  output logic                    saturated_o
);

  localparam int unsigned TabSize = 1 << LOG_TABLE_BITS;
  localparam int unsigned CW      = COUNT_WIDTH;

  typedef logic [FracW-1:0] frac_tab_t [TabSize];

  function automatic frac_tab_t build_tab();
    frac_tab_t t;
    for (int unsigned i = 0; i < TabSize; i++) begin
      t[i] = frac_entry(i, LOG_TABLE_BITS);
    end
    return t;
  endfunction

  localparam frac_tab_t FracTab = build_tab();

  typedef enum logic [3:0] {
    S_IDLE, S_MAP1, S_MAP2, S_MAP3, S_DER, S_CHK, S_NORM, S_LN, S_ACC, S_DIV, S_DWAIT
  } state_e;

  state_e                 state_q, state_d;
  logic [31:0]            x_q, x_d;
  logic [RateW-1:0]       r_q, r_d;
  logic signed [SumW-1:0] sum_q, sum_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic                   meas_q, meas_d;
  logic                   zflag_q, zflag_d;
  logic [64:0]            prod_q, prod_d;
  logic [63:0]            norm_q, norm_d;
  logic [5:0]             sh_q, sh_d;
  logic [2:0]             step_q, step_d;
  logic                   neg_q, neg_d;
  logic [CfgW-1:0]        trans_q, trans_d;
  logic [CfgW-1:0]        iter_q, iter_d;
  logic                   done_q, done_d;
  logic [ExpoW-1:0]       expo_q, expo_d;
  logic                   zout_q, zout_d;
  logic                   sat_q, sat_d;

  logic [32:0]     mul_a;
  logic [31:0]     mul_b;
  logic [CW-1:0]   tcnt, mcnt;
  logic [31:0]     om;
  logic [32:0]     twox, dmag;
  logic [5:0]      sa;
  logic signed [31:0] l2;
  logic [31:0]     l2mag;
  logic [SumW-1:0] sum_mag;
  logic            div_start, div_done;
  logic [DivW-1:0] div_q;

  assign tcnt = CW'(trans_q);
  assign mcnt = CW'(iter_q);
  assign om   = ({1'b0, x_q} <= OneQ31) ? 32'(OneQ31 - {1'b0, x_q}) : 32'd0;
  assign twox = {x_q, 1'b0};
  assign dmag = (twox > OneQ31) ? (twox - OneQ31) : (OneQ31 - twox);
  assign sa   = 6'd32 >> step_q;
  assign l2   = ((32'sd4 - $signed({26'd0, sh_q})) <<< FracW)
              + $signed({8'd0, FracTab[norm_q[62 -: LOG_TABLE_BITS]]});
  assign l2mag   = l2[31] ? 32'(-l2) : 32'(l2);
  assign sum_mag = sum_q[SumW-1] ? SumW'(-sum_q) : SumW'(sum_q);
  assign div_start = (state_q == S_DIV);
  assign busy      = (state_q != S_IDLE);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_MAP1: begin
        mul_a = {1'b0, x_q};
        mul_b = om;
      end
      S_MAP2: begin
        mul_a = 33'(r_q);
        mul_b = prod_q[62:31];
      end
      S_DER: begin
        mul_a = dmag;
        mul_b = 32'(r_q);
      end
      S_LN: begin
        mul_a = {1'b0, l2mag};
        mul_b = Ln2Q32;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    x_d     = x_q;
    r_d     = r_q;
    sum_d   = sum_q;
    cnt_d   = cnt_q;
    meas_d  = meas_q;
    zflag_d = zflag_q;
    prod_d  = prod_q;
    norm_d  = norm_q;
    sh_d    = sh_q;
    step_d  = step_q;
    neg_d   = neg_q;
    trans_d = trans_q;
    iter_d  = iter_q;
    done_d  = 1'b0;
    expo_d  = expo_q;
    zout_d  = zout_q;
    sat_d   = sat_q;

    if (cfg_we_i) begin
      if (cfg_idx_i == REG_TRANSIENT) begin
        trans_d = cfg_data_i;
      end else begin
        iter_d = cfg_data_i;
      end
    end

    case (state_q)
      S_IDLE: begin
        if (start) begin
          r_d     = growth_rate_i;
          x_d     = HalfQ31;
          sum_d   = '0;
          zflag_d = 1'b0;
          cnt_d   = '0;
          if (tcnt != '0) begin
            meas_d  = 1'b0;
            state_d = S_MAP1;
          end else if (mcnt != '0) begin
            meas_d  = 1'b1;
            state_d = S_DER;
          end else begin
            expo_d  = '0;
            sat_d   = 1'b0;
            zout_d  = 1'b0;
            done_d  = 1'b1;
          end
        end
      end
      S_MAP1: begin
        prod_d  = 65'(mul_a * mul_b);
        state_d = S_MAP2;
      end
      S_MAP2: begin
        prod_d  = 65'(mul_a * mul_b);
        state_d = S_MAP3;
      end
      S_MAP3: begin
        x_d = (prod_q[64:60] != '0) ? 32'hFFFF_FFFF : prod_q[59:28];
        if (!meas_q) begin
          if (cnt_q + 1'b1 == tcnt) begin
            cnt_d = '0;
            if (mcnt != '0) begin
              meas_d  = 1'b1;
              state_d = S_DER;
            end else begin
              expo_d  = '0;
              sat_d   = 1'b0;
              zout_d  = 1'b0;
              done_d  = 1'b1;
              state_d = S_IDLE;
            end
          end else begin
            cnt_d   = cnt_q + 1'b1;
            state_d = S_MAP1;
          end
        end else begin
          if (cnt_q + 1'b1 == mcnt) begin
            state_d = S_DIV;
          end else begin
            cnt_d   = cnt_q + 1'b1;
            state_d = S_DER;
          end
        end
      end
      S_DER: begin
        prod_d  = 65'(mul_a * mul_b);
        state_d = S_CHK;
      end
      S_CHK: begin
        if (prod_q[63:0] == '0) begin
          sum_d   = sum_q + LogFloor;
          zflag_d = 1'b1;
          state_d = S_MAP1;
        end else begin
          norm_d  = prod_q[63:0];
          sh_d    = '0;
          step_d  = '0;
          state_d = S_NORM;
        end
      end
      S_NORM: begin
        if ((norm_q >> (7'd64 - {1'b0, sa})) == '0) begin
          norm_d = norm_q << sa;
          sh_d   = sh_q + sa;
        end
        step_d = step_q + 1'b1;
        if (step_q == 3'd5) begin
          state_d = S_LN;
        end
      end
      S_LN: begin
        prod_d  = 65'(mul_a * mul_b);
        neg_d   = l2[31];
        state_d = S_ACC;
      end
      S_ACC: begin
        sum_d   = neg_q ? (sum_q - $signed({20'd0, prod_q[63:32]}))
                        : (sum_q + $signed({20'd0, prod_q[63:32]}));
        state_d = S_MAP1;
      end
      S_DIV: begin
        state_d = S_DWAIT;
      end
      S_DWAIT: begin
        if (div_done) begin
          zout_d = zflag_q;
          if (sum_q[SumW-1]) begin
            if (div_q > DivW'(OneQ31)) begin
              sat_d  = 1'b1;
              expo_d = 32'h8000_0000;
            end else begin
              sat_d  = 1'b0;
              expo_d = 32'(-div_q);
            end
          end else begin
            if (div_q > DivW'(32'h7FFF_FFFF)) begin
              sat_d  = 1'b1;
              expo_d = 32'h7FFF_FFFF;
            end else begin
              sat_d  = 1'b0;
              expo_d = div_q[31:0];
            end
          end
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      meas_q  <= 1'b0;
      zflag_q <= 1'b0;
      cnt_q   <= '0;
      step_q  <= '0;
      trans_q <= TransientReset;
      iter_q  <= IterationReset;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      meas_q  <= meas_d;
      zflag_q <= zflag_d;
      cnt_q   <= cnt_d;
      step_q  <= step_d;
      trans_q <= trans_d;
      iter_q  <= iter_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    r_q    <= r_d;
    sum_q  <= sum_d;
    prod_q <= prod_d;
    norm_q <= norm_d;
    sh_q   <= sh_d;
    neg_q  <= neg_d;
    expo_q <= expo_d;
    zout_q <= zout_d;
    sat_q  <= sat_d;
  end

  lmle_div #(
    .DW(DivW),
    .VW(CW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(sum_mag[DivW-1:0]),
    .divisor_i (mcnt),
    .done_o    (div_done),
    .quotient_o(div_q)
  );

  assign done_o                 = done_q;
  assign exponent_o             = $signed(expo_q);
  assign zero_derivative_seen_o = zout_q;
  assign saturated_o            = sat_q;

endmodule

// ===== tb/sv/tb_logistic_map_lyapunov_estimator_unit.sv =====
module tb_logistic_map_lyapunov_estimator_unit;
  import lmle_pkg::*;

  localparam int unsigned TblBits = LogTableBitsDef;
  localparam longint CycleLimit = 6_000_000;

  typedef struct {
    logic signed [ExpoW-1:0] expo;
    logic                    zero_seen;
    logic                    sat;
  } lyap_result_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  logic [RateW-1:0]        growth_rate_i;
  logic                    cfg_we_i;
  logic                    cfg_idx_i;
  logic [CfgW-1:0]         cfg_data_i;
  logic                    done_o;
  logic signed [ExpoW-1:0] exponent_o;
  logic                    zero_derivative_seen_o;
  logic                    saturated_o;

  logic [FracW-1:0] log2_frac [2**TblBits];
  logic [RateW-1:0] rate_queue [$];
  lyap_result_t     lyap_queue [$];
  logic [CfgW-1:0]  transient_shadow;
  logic [CfgW-1:0]  measured_shadow;
  int               idle_pct;
  bit               request_taken;
  longint           cycle_count;
  int               errors;
  int               requests;
  int               results;
  int               zero_hits;
  int               sat_hits;

  logistic_map_lyapunov_estimator_unit i_dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .start                 (start),
    .busy                  (busy),
    .growth_rate_i         (growth_rate_i),
    .cfg_we_i              (cfg_we_i),
    .cfg_idx_i             (cfg_idx_i),
    .cfg_data_i            (cfg_data_i),
    .done_o                (done_o),
    .exponent_o            (exponent_o),
    .zero_derivative_seen_o(zero_derivative_seen_o),
    .saturated_o           (saturated_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic logic [31:0] map_step(logic [31:0] x, longint unsigned r);
    longint unsigned om;
    longint unsigned q;
    longint unsigned n;
    om = (x <= 32'h8000_0000) ? (64'h8000_0000 - x) : 64'd0;
    q  = (longint'(x) * om) >> 31;
    n  = (r * q) >> 28;
    return (n > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : n[31:0];
  endfunction

  function automatic longint natural_log(longint unsigned m);
    int               p;
    int unsigned      idx;
    longint           l2;
    longint unsigned  mag;
    longint unsigned  lnmag;
    p = 63;
    while (p > 0 && m[p] == 1'b0) p--;
    if (p >= TblBits) idx = 32'((m >> (p - TblBits)) & ((1 << TblBits) - 1));
    else idx = 32'((m << (TblBits - p)) & ((1 << TblBits) - 1));
    l2    = longint'(p - 59) * (longint'(1) << 24) + longint'(log2_frac[idx]);
    mag   = (l2 < 0) ? -l2 : l2;
    lnmag = (mag * 64'hB172_17F8) >> 32;
    return (l2 < 0) ? -longint'(lnmag) : longint'(lnmag);
  endfunction

  function automatic lyap_result_t predict_exponent(logic [RateW-1:0] rate,
                                                    logic [CfgW-1:0] tcount,
                                                    logic [CfgW-1:0] mcount);
    lyap_result_t    res;
    logic [31:0]     x;
    longint unsigned r;
    longint unsigned twox;
    longint unsigned d;
    longint unsigned m;
    longint          sum;
    longint unsigned mag;
    longint unsigned q;
    r   = rate;
    x   = 32'h4000_0000;
    sum = 0;
    res.zero_seen = 1'b0;
    res.sat = 1'b0;
    res.expo = '0;
    for (int i = 0; i < tcount; i++) x = map_step(x, r);
    for (int i = 0; i < mcount; i++) begin
      twox = longint'(x) << 1;
      d = (twox > 64'h8000_0000) ? (twox - 64'h8000_0000) : (64'h8000_0000 - twox);
      m = r * d;
      if (m == 0) begin
        sum += -longint'(690) * (longint'(1) << 24);
        res.zero_seen = 1'b1;
      end else begin
        sum += natural_log(m);
      end
      x = map_step(x, r);
    end
    if (mcount != 0) begin
      mag = (sum < 0) ? -sum : sum;
      q = mag / mcount;
      if (sum < 0) begin
        if (q > 64'h8000_0000) begin
          q = 64'h8000_0000;
          res.sat = 1'b1;
        end
        res.expo = ExpoW'(-longint'(q));
      end else begin
        if (q > 64'h7FFF_FFFF) begin
          q = 64'h7FFF_FFFF;
          res.sat = 1'b1;
        end
        res.expo = ExpoW'(q);
      end
    end
    return res;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch on %s at cycle %0d: got %0d, expected %0d", what, cycle_count, got,
             want);
    errors++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    lyap_result_t want;
    if (!rst_ni) begin
      transient_shadow <= TransientReset;
      measured_shadow  <= IterationReset;
      request_taken = 1'b0;
    end else begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("tb_logistic_map_lyapunov_estimator_unit NOT OK");
        $finish;
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_TRANSIENT) transient_shadow <= cfg_data_i;
        else measured_shadow <= cfg_data_i;
      end
      if (done_o) begin
        results++;
        if (lyap_queue.size() == 0) begin
          report("unexpected result", exponent_o, 0);
        end else begin
          want = lyap_queue.pop_front();
          if (exponent_o !== want.expo) report("exponent", exponent_o, want.expo);
          if (zero_derivative_seen_o !== want.zero_seen)
            report("zero_derivative_seen", zero_derivative_seen_o, want.zero_seen);
          if (saturated_o !== want.sat) report("saturated", saturated_o, want.sat);
          zero_hits += want.zero_seen;
          sat_hits += want.sat;
        end
      end
      request_taken = start && !busy;
      if (request_taken) begin
        requests++;
        lyap_queue.insert(lyap_queue.size(),
                          predict_exponent(growth_rate_i, transient_shadow,
                                           measured_shadow));
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (request_taken) begin
        void'(rate_queue.pop_front());
        request_taken = 1'b0;
      end
      if (start && busy) begin
        start <= 1'b1;
      end else if (rate_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        start <= 1'b1;
        growth_rate_i <= rate_queue[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  function automatic logic [RateW-1:0] random_rate();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return RateW'($urandom_range(0, 32'h4000_0000));
    else if (pick < 85) return RateW'($urandom_range(32'h3000_0000, 32'h4000_0000));
    else return RateW'($urandom() & 32'h7FFF_FFFF);
  endfunction

  task automatic wait_drained();
    do @(posedge clk_i);
    while (rate_queue.size() != 0 || lyap_queue.size() != 0 || start || busy);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_counts(logic [CfgW-1:0] tcount, logic [CfgW-1:0] mcount);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_TRANSIENT;
    cfg_data_i <= tcount;
    @(negedge clk_i);
    cfg_idx_i  <= REG_ITERATION;
    cfg_data_i <= mcount;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic enqueue_rate(logic [RateW-1:0] rate);
    rate_queue.insert(rate_queue.size(), rate);
  endtask

  task automatic push_random(int n);
    for (int i = 0; i < n; i++) enqueue_rate(random_rate());
  endtask

  initial begin
    logic [RateW-1:0] directed [$];
    directed = '{31'h0, 31'h4000_0000, 31'h7FFF_FFFF, 31'h2000_0000, 31'h1000_0000,
                 31'h0000_0001, 31'h3800_0000, 31'h3A00_0000, 31'h3FFF_FFFF,
                 31'h4000_0001, 31'h5555_5555, 31'h2AAA_AAAA, 31'h3C00_0000,
                 31'h0800_0000, 31'h3000_0000, 31'h6000_0000, 31'h3E8F_5C29};
    for (int i = 0; i < 2**TblBits; i++) begin
      longint unsigned y;
      logic [FracW-1:0] acc;
      y = 64'h4000_0000 + (longint'(i) << (30 - TblBits));
      acc = '0;
      for (int k = 0; k < FracW; k++) begin
        y = (y * y) >> 30;
        acc = acc << 1;
        if (y >= 64'h8000_0000) begin
          y = y >> 1;
          acc[0] = 1'b1;
        end
      end
      log2_frac[i] = acc;
    end
    cycle_count   = 0;
    errors        = 0;
    requests      = 0;
    results       = 0;
    zero_hits     = 0;
    sat_hits      = 0;
    idle_pct      = 17;
    start         = 1'b0;
    growth_rate_i = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_TRANSIENT;
    cfg_data_i    = '0;
    rst_ni        = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    enqueue_rate(31'h4000_0000);
    enqueue_rate(31'h3800_0000);
    enqueue_rate(31'h2000_0000);
    set_counts(16'd0, 16'd1);
    foreach (directed[i]) enqueue_rate(directed[i]);
    set_counts(16'd20, 16'd20);
    foreach (directed[i]) enqueue_rate(directed[i]);
    push_random(60);
    idle_pct = 57;
    set_counts(16'd5, 16'd0);
    push_random(5);
    set_counts(16'hFFFF, 16'd1);
    enqueue_rate(random_rate());
    set_counts(16'd0, 16'hFFFF);
    enqueue_rate(31'h3C00_0000);
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 4) idle_pct = 0;
      set_counts($urandom_range(0, 40), $urandom_range(1, 40));
      push_random(22);
    end
    wait_drained();
    repeat (100) @(posedge clk_i);

    $display("%0d requests over several count settings, %0d results checked", requests,
             results);
    $display("%0d results with a zero derivative, %0d saturated", zero_hits, sat_hits);
    if (errors == 0) begin
      $display("tb_logistic_map_lyapunov_estimator_unit OK");
    end else begin
      $display("tb_logistic_map_lyapunov_estimator_unit NOT OK");
    end
    $finish;
  end

endmodule

// ===== logistic_map_lyapunov_estimator_unit.f =====
hdl/lmle_pkg.sv
hdl/lmle_div.sv
hdl/logistic_map_lyapunov_estimator_unit.sv
tb/sv/tb_logistic_map_lyapunov_estimator_unit.sv
